### sv/plti_pkg.sv
// shared types, constants and codes for the piecewise linear table interpolator
// no dependencies; imported by every module of the block except plti_ram

package plti_pkg;

  // table geometry
  localparam int MAX_POINTS = 64;
  localparam int PIDX_W     = $clog2(MAX_POINTS);

  // fixed field widths
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // request queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // iteration counts of the serial multiply and divide
  localparam int PROD_W   = 2 * DATA_W + 1;
  localparam int MUL_STEPS = DATA_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int MDCNT_W  = $clog2(DIV_STEPS);

  // request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_LOW      = 2'd0;
  localparam logic [STAT_W-1:0] ST_HIGH     = 2'd1;
  localparam logic [STAT_W-1:0] ST_INTERIOR = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE     = 2'd3;

  // one classified request as it waits in the queue
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } op_t;

  // front status seen by the top level
  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] count;
  } fe_stat_t;

  // segment operands handed to the multiply/divide unit
  typedef struct packed {
    logic [DATA_W:0]   mag;
    logic [DATA_W-1:0] dq;
    logic [DATA_W-1:0] dx;
  } md_req_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD0,
    B_RDL,
    B_SCAN,
    B_MD,
    B_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

endpackage

### sv/plti_ram.sv
// generic single-port ram with registered read
// no dependencies

module plti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/plti_front.sv
// front end: accepts requests, classifies them and queues them for the back end
// depends on plti_pkg

module plti_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_kind_i,
  input  logic [103:0]           in_data_i,
  output plti_pkg::op_t          op_o,
  input  logic                   op_pop_i,
  output plti_pkg::fe_stat_t     stat_o
);
  import plti_pkg::*;

  op_t               q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  op_t               op_in;

  // classify: a query carries its abscissa in the x slot
  always_comb begin
    op_in.kind = in_kind_i;
    op_in.idx  = in_data_i[5:0];
    op_in.y    = in_data_i[69:38];
    if (in_kind_i == KIND_QUERY) begin
      op_in.x = in_data_i[101:70];
    end else begin
      op_in.x = in_data_i[37:6];
    end
  end

  assign in_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign push       = in_valid_i && in_ready_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (op_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !op_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && op_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= op_in;
    end
  end

  assign op_o         = q_mem_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.count = cnt_q;

endmodule

### sv/plti_muldiv.sv
// serial multiply then restoring divide: (mag * dq) / dx, one bit a cycle
// depends on plti_pkg

module plti_muldiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  plti_pkg::md_req_t          req_i,
  output logic                       done_o,
  output logic [plti_pkg::DATA_W-1:0] quot_o
);
  import plti_pkg::*;

  md_state_e          st_q, st_d;
  logic [MDCNT_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [DATA_W:0]    mag_q;
  logic [DATA_W-1:0]  dq_q, dq_d, dx_q;
  logic [DATA_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0]  quot_q, quot_d;
  logic [DATA_W:0]    trial;
  logic [DATA_W:0]    trial_sub;
  logic               done;

  assign trial     = {rem_q, acc_q[PROD_W-1]};
  assign trial_sub = trial - {1'b0, dx_q};

  // sequencer for both phases
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    done   = 1'b0;
    unique case (st_q)
      MD_IDLE: begin
        if (start_i) begin
          st_d  = MD_MUL;
          cnt_d = '0;
          acc_d = '0;
          dq_d  = req_i.dq;
        end
      end
      MD_MUL: begin
        // shift-add over multiplier bits, msb first
        acc_d = {acc_q[PROD_W-2:0], 1'b0}
              + (dq_q[DATA_W-1] ? PROD_W'(mag_q) : PROD_W'(0));
        dq_d  = {dq_q[DATA_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MDCNT_W'(MUL_STEPS - 1)) begin
          st_d  = MD_DIV;
          cnt_d = '0;
          rem_d = '0;
        end
      end
      MD_DIV: begin
        // restoring step: remainder stays below the divisor
        if (!trial_sub[DATA_W]) begin
          rem_d  = trial_sub[DATA_W-1:0];
          quot_d = {quot_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d  = trial[DATA_W-1:0];
          quot_d = {quot_q[DATA_W-2:0], 1'b0};
        end
        acc_d = {acc_q[PROD_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MDCNT_W'(DIV_STEPS - 1)) begin
          st_d = MD_IDLE;
          done = 1'b1;
        end
      end
      default: st_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= MD_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (st_q == MD_IDLE && start_i) begin
      mag_q <= req_i.mag;
      dx_q  <= req_i.dx;
    end
  end

  assign done_o = done;
  assign quot_o = quot_d;

endmodule

### sv/plti_back.sv
// back end: table writes, clamp checks, segment scan and result register
// depends on plti_pkg, plti_ram and plti_muldiv

module plti_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [plti_pkg::CNT_W-1:0]  point_count_i,
  input  plti_pkg::op_t               op_i,
  input  logic                        op_valid_i,
  output logic                        op_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [plti_pkg::DATA_W-1:0] out_value_o,
  output logic [plti_pkg::STAT_W-1:0] out_status_o
);
  import plti_pkg::*;

  back_state_e         st_q, st_d;
  logic [PIDX_W-1:0]   k_q, k_d;
  logic [PIDX_W-1:0]   last_idx;
  logic signed [DATA_W-1:0] q_q, px_q, py_q, cur_x, cur_y;
  logic [DATA_W-1:0]   sy1_q;
  logic                sneg_q, match_q, match_d;
  md_req_t             sreq_q;
  logic [DATA_W-1:0]   res_val_q, res_val_d;
  logic [STAT_W-1:0]   res_st_q, res_st_d;
  logic                out_valid_q;
  logic [DATA_W-1:0]   out_value_q;
  logic [STAT_W-1:0]   out_status_q;
  logic                seg_hit, load_out, md_start, md_done;
  logic [DATA_W-1:0]   md_quot;
  logic [DATA_W:0]     dy;
  logic                ram_we, ram_re;
  logic [PIDX_W-1:0]   ram_addr;
  logic [2*DATA_W-1:0] ram_rdata;

  // last point in use, count clamped to the table
  always_comb begin
    if (point_count_i == '0) begin
      last_idx = '0;
    end else if (32'(point_count_i) > 32'(MAX_POINTS)) begin
      last_idx = PIDX_W'(MAX_POINTS - 1);
    end else begin
      last_idx = PIDX_W'(point_count_i - 1'b1);
    end
  end

  assign cur_x   = ram_rdata[2*DATA_W-1:DATA_W];
  assign cur_y   = ram_rdata[DATA_W-1:0];
  assign seg_hit = (q_q >= px_q) && (q_q < cur_x);
  assign dy      = {cur_y[DATA_W-1], cur_y} - {py_q[DATA_W-1], py_q};
  assign load_out = !out_valid_q || out_ready_i;

  // control sequencer
  always_comb begin
    st_d      = st_q;
    k_d       = k_q;
    match_d   = match_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    op_pop_o  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = '0;
    md_start  = 1'b0;
    unique case (st_q)
      B_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          if (op_i.kind == KIND_WRITE) begin
            ram_we   = (32'(op_i.idx) < 32'(MAX_POINTS));
            ram_addr = PIDX_W'(op_i.idx);
          end else begin
            ram_re   = 1'b1;
            ram_addr = '0;
            st_d     = B_RD0;
          end
        end
      end
      B_RD0: begin
        ram_re   = 1'b1;
        ram_addr = last_idx;
        st_d     = B_RDL;
      end
      B_RDL: begin
        if (q_q <= px_q) begin
          res_val_d = py_q;
          res_st_d  = ST_LOW;
          st_d      = B_OUT;
        end else if (q_q >= cur_x) begin
          res_val_d = cur_y;
          res_st_d  = ST_HIGH;
          st_d      = B_OUT;
        end else begin
          ram_re   = 1'b1;
          ram_addr = PIDX_W'(1);
          k_d      = PIDX_W'(1);
          match_d  = 1'b0;
          st_d     = B_SCAN;
        end
      end
      B_SCAN: begin
        // one entry a cycle; later matches overwrite earlier ones
        if (seg_hit) begin
          match_d = 1'b1;
        end
        if (k_q == last_idx) begin
          if (seg_hit || match_q) begin
            st_d = B_MD;
          end else begin
            res_val_d = '0;
            res_st_d  = ST_NONE;
            st_d      = B_OUT;
          end
        end else begin
          ram_re   = 1'b1;
          ram_addr = k_q + 1'b1;
          k_d      = k_q + 1'b1;
        end
      end
      B_MD: begin
        md_start = 1'b1;
        if (md_done) begin
          res_val_d = sneg_q ? sy1_q - md_quot : sy1_q + md_quot;
          res_st_d  = ST_INTERIOR;
          st_d      = B_OUT;
        end
      end
      B_OUT: begin
        if (load_out) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_OUT && load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    match_q   <= match_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (st_q == B_IDLE) begin
      q_q <= op_i.x;
    end
    if (st_q == B_RD0 || st_q == B_SCAN) begin
      px_q <= cur_x;
      py_q <= cur_y;
    end
    if (st_q == B_SCAN && seg_hit) begin
      sy1_q       <= py_q;
      sneg_q      <= dy[DATA_W];
      sreq_q.mag  <= dy[DATA_W] ? -dy : dy;
      sreq_q.dq   <= q_q - px_q;
      sreq_q.dx   <= cur_x - px_q;
    end
    if (st_q == B_OUT && load_out) begin
      out_value_q  <= res_val_q;
      out_status_q <= res_st_q;
    end
  end

  plti_ram #(
    .WIDTH(2 * DATA_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i({op_i.x, op_i.y}),
    .rdata_o(ram_rdata)
  );

  plti_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .req_i  (sreq_q),
    .done_o (md_done),
    .quot_o (md_quot)
  );

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

### sv/piecewise_linear_table_interp.sv
// Piecewise linear table interpolator, signed Q16.16. Requests with tuser 0
// store one breakpoint (no result) in the back end; queries with tuser 1 give
// one result. A clamped query reads the first and last points, then loads the
// output register once it is free; an interior query also scans the points in
// use (one table read a cycle on the single ram port), then runs the serial
// multiply (32 steps) and restoring divide (65 steps) before the output
// register loads. A two-deep request queue lets the input side keep accepting,
// until the queue fills, while the back end works or a result waits in the
// output register.
// Table entries are not cleared at reset and must be written before use.
// depends on plti_pkg, plti_front, plti_back

module piecewise_linear_table_interp (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: point_count
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // point_index, point_x, point_y, query_x, pad
  input  logic [0:0]   s_axis_tuser,  // kind
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // interp_value
  output logic [1:0]   m_axis_tuser   // status
);
  import plti_pkg::*;

  logic [CNT_W-1:0] point_count_q;
  op_t              op;
  logic             op_pop;
  fe_stat_t         fe_stat;

  // point count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  plti_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_kind_i (s_axis_tuser[0]),
    .in_data_i (s_axis_tdata),
    .op_o      (op),
    .op_pop_i  (op_pop),
    .stat_o    (fe_stat)
  );

  plti_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .point_count_i(point_count_q),
    .op_i         (op),
    .op_valid_i   (fe_stat.valid),
    .op_pop_o     (op_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

  // back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) op_pop |-> fe_stat.valid)
    else $error("request popped from empty queue");

  // queue occupancy stays within its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_stat.count <= QCNT_W'(QDEPTH))
    else $error("request queue overflow");

  // a no-segment result carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_NONE) |-> (m_axis_tdata == '0))
    else $error("no-segment result not zero");

endmodule
